[src/random_cell_pool_macros.svh]
// Assertion macros shared by the checker of the random cell pool.
// Depends on nothing; included by the checker file.
`ifndef RANDOM_CELL_POOL_MACROS_SVH
`define RANDOM_CELL_POOL_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define RCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define RCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rcp_pkg.sv]
// Package of the random cell pool: sizes, action and status codes, and the
// memory request struct. Depends on nothing.
`default_nettype none

package rcp_pkg;

  // Grid geometry: the coordinate fields are four bits wide.
  localparam int GRID_SIDE  = 16;
  localparam int COORD_W    = 4;
  localparam int CELL_TOTAL = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W     = $clog2(CELL_TOTAL);
  localparam int CNT_W      = $clog2(CELL_TOTAL + 1);
  localparam int RND_W      = 15;

  typedef enum logic [1:0] {
    ACT_REFILL = 2'd0,
    ACT_PICK   = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // One access to the pool memory.
  typedef struct packed {
    logic              refill;
    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;
    logic              wr_en;
    logic [CELL_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

[src/rcp_if.sv]
// Valid/ready channel interfaces of the random cell pool: requests in and
// results out. Depends on rcp_pkg.
`default_nettype none

interface rcp_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [rcp_pkg::RND_W-1:0]  random_value;
  logic [rcp_pkg::COORD_W-1:0] target_x;
  logic [rcp_pkg::COORD_W-1:0] target_y;

  modport source (output valid, action, random_value, target_x, target_y, input ready);
  modport sink   (input valid, action, random_value, target_x, target_y, output ready);
endinterface

interface rcp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [rcp_pkg::COORD_W-1:0] picked_x;
  logic [rcp_pkg::COORD_W-1:0] picked_y;
  logic [rcp_pkg::CNT_W-1:0]   remaining;

  modport source (output valid, status, picked_x, picked_y, remaining, input ready);
  modport sink   (input valid, status, picked_x, picked_y, remaining, output ready);
endinterface

`default_nettype wire

[src/rcp_mem.sv]
// Pool memory: one synchronous read port and one write port, with a valid
// bit per entry so that an unwritten entry reads as its own index.
// Depends on rcp_pkg.
`default_nettype none

module rcp_mem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rcp_pkg::mem_req_t          req_i,
  output logic [rcp_pkg::CELL_W-1:0]      rd_data_o
);

  logic [rcp_pkg::CELL_W-1:0]     mem_q [rcp_pkg::CELL_TOTAL];
  logic [rcp_pkg::CELL_TOTAL-1:0] vld_q;
  logic [rcp_pkg::CELL_W-1:0]     rd_q;
  logic [rcp_pkg::CELL_W-1:0]     rd_addr_q;
  logic                           rd_vld_q;

  // Storage array: written and read in one clocked block, no reset.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q      <= mem_q[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  // Valid bits: a refill clears them all at once, so the pool returns to
  // identity order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.refill) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // An entry never written since the last refill holds its own index.
  assign rd_data_o = rd_vld_q ? rd_q : rd_addr_q;

endmodule

`default_nettype wire

[src/rcp_mod.sv]
// Iterative remainder unit: one restoring step per cycle over the random
// value, reduced by the live count. Depends on rcp_pkg.
`default_nettype none

module rcp_mod (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rcp_pkg::RND_W-1:0]  dividend_i,
  input  wire logic [rcp_pkg::CNT_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [rcp_pkg::CELL_W-1:0]      rem_o
);

  localparam int StepW = $clog2(rcp_pkg::RND_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [StepW-1:0]            step_q, step_d;
  logic [rcp_pkg::CELL_W-1:0]  rem_q, rem_d;
  logic [rcp_pkg::RND_W-1:0]   dvd_q, dvd_d;
  logic [rcp_pkg::CNT_W-1:0]   dsr_q, dsr_d;
  logic [rcp_pkg::CELL_W:0]    trial;

  // The partial remainder stays below the divisor, which is at most the
  // cell total, so the shifted trial value fits one bit above an index.
  assign trial = {rem_q, dvd_q[rcp_pkg::RND_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(rcp_pkg::RND_W - 1);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= dsr_q) begin
        rem_d = rcp_pkg::CELL_W'(trial - dsr_q);
      end else begin
        rem_d = trial[rcp_pkg::CELL_W-1:0];
      end
      dvd_d = {dvd_q[rcp_pkg::RND_W-2:0], 1'b0};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      dvd_q  <= dvd_d;
      dsr_q  <= dsr_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[src/random_cell_pool.sv]
// Random cell pool: a memory of free cell numbers and a live count, served
// one item at a time. A pick runs the 15-step remainder unit, followed by
// two memory reads and a write-back. A remove scans the live entries at one
// memory read per cycle. No clearing pass follows reset: per-entry valid
// bits give identity order at once. A new item is taken whenever the
// sequencer is idle, even while a result waits at the output register.
// Depends on rcp_pkg, rcp_if, rcp_mem and rcp_mod.
`default_nettype none

module random_cell_pool (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rcp_req_if.sink    req_i,
  rcp_rsp_if.source  rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD_SLOT,
    S_SLOT_WAIT,
    S_LAST_WAIT,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                        state_q, state_d;
  logic [rcp_pkg::CNT_W-1:0]     count_q, count_d;
  logic [1:0]                    act_q, act_d;
  logic [rcp_pkg::CELL_W-1:0]    tgt_q, tgt_d;
  logic [rcp_pkg::CELL_W-1:0]    slot_q, slot_d;
  logic [rcp_pkg::CNT_W-1:0]     issue_q, issue_d;
  logic                          chk_vld_q, chk_vld_d;
  logic [rcp_pkg::CELL_W-1:0]    chk_addr_q, chk_addr_d;
  rcp_pkg::status_e              res_status_q, res_status_d;
  logic [rcp_pkg::COORD_W-1:0]   res_x_q, res_x_d;
  logic [rcp_pkg::COORD_W-1:0]   res_y_q, res_y_d;
  logic                          out_vld_q, out_vld_d;
  rcp_pkg::status_e              out_status_q, out_status_d;
  logic [rcp_pkg::COORD_W-1:0]   out_x_q, out_x_d;
  logic [rcp_pkg::COORD_W-1:0]   out_y_q, out_y_d;
  logic [rcp_pkg::CNT_W-1:0]     out_rem_q, out_rem_d;

  rcp_pkg::mem_req_t             mem_req;
  logic [rcp_pkg::CELL_W-1:0]    rd_data;
  logic                          div_start;
  logic                          div_done;
  logic [rcp_pkg::CELL_W-1:0]    div_rem;
  logic [rcp_pkg::CNT_W-1:0]     cnt_m1;

  rcp_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  rcp_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.random_value),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign cnt_m1 = count_q - rcp_pkg::CNT_W'(1);

  // Sequencer: a pick reads the chosen slot, a remove finds its cell; then
  // read the last live entry, write it back into the slot and shrink the count.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    act_d        = act_q;
    tgt_d        = tgt_q;
    slot_d       = slot_q;
    issue_d      = issue_q;
    chk_vld_d    = 1'b0;
    chk_addr_d   = chk_addr_q;
    res_status_d = res_status_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    out_vld_d    = out_vld_q & ~rsp_o.ready;
    out_status_d = out_status_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_rem_d    = out_rem_q;
    mem_req      = '0;
    div_start    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d        = req_i.action;
          tgt_d        = {req_i.target_y, req_i.target_x};
          res_status_d = rcp_pkg::ST_OK;
          res_x_d      = '0;
          res_y_d      = '0;
          unique case (req_i.action)
            rcp_pkg::ACT_REFILL: begin
              mem_req.refill = 1'b1;
              count_d        = rcp_pkg::CNT_W'(rcp_pkg::CELL_TOTAL);
              state_d        = S_DONE;
            end
            rcp_pkg::ACT_PICK: begin
              if (count_q == '0) begin
                res_status_d = rcp_pkg::ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            rcp_pkg::ACT_REMOVE: begin
              if (count_q == '0) begin
                res_status_d = rcp_pkg::ST_NOT_FOUND;
                state_d      = S_DONE;
              end else begin
                issue_d = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          slot_d  = div_rem;
          state_d = S_RD_SLOT;
        end
      end
      S_RD_SLOT: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = slot_q;
        state_d         = S_SLOT_WAIT;
      end
      S_SLOT_WAIT: begin
        // The slot's cell is the result of a pick; then fetch the last entry.
        if (act_q == rcp_pkg::ACT_PICK) begin
          res_x_d = rd_data[rcp_pkg::COORD_W-1:0];
          res_y_d = rd_data[rcp_pkg::CELL_W-1:rcp_pkg::COORD_W];
        end
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = cnt_m1[rcp_pkg::CELL_W-1:0];
        state_d         = S_LAST_WAIT;
      end
      S_LAST_WAIT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = slot_q;
        mem_req.wr_data = rd_data;
        count_d         = cnt_m1;
        state_d         = S_DONE;
      end
      S_SCAN: begin
        // Reads are issued one per cycle, and each is checked once the memory has registered its data.
        if (chk_vld_q && (rd_data == tgt_q)) begin
          slot_d  = chk_addr_q;
          state_d = S_SLOT_WAIT;
        end else if (chk_vld_q && ({1'b0, chk_addr_q} == cnt_m1)) begin
          res_status_d = rcp_pkg::ST_NOT_FOUND;
          state_d      = S_DONE;
        end else if (issue_q < count_q) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = issue_q[rcp_pkg::CELL_W-1:0];
          chk_vld_d       = 1'b1;
          chk_addr_d      = issue_q[rcp_pkg::CELL_W-1:0];
          issue_d         = issue_q + rcp_pkg::CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_x_d      = res_x_q;
          out_y_d      = res_y_q;
          out_rem_d    = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, count and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= rcp_pkg::CNT_W'(rcp_pkg::CELL_TOTAL);
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      chk_vld_q    <= chk_vld_d;
      out_vld_q    <= out_vld_d;
      act_q        <= act_d;
      tgt_q        <= tgt_d;
      slot_q       <= slot_d;
      issue_q      <= issue_d;
      chk_addr_q   <= chk_addr_d;
      res_status_q <= res_status_d;
      res_x_q      <= res_x_d;
      res_y_q      <= res_y_d;
      out_status_q <= out_status_d;
      out_x_q      <= out_x_d;
      out_y_q      <= out_y_d;
      out_rem_q    <= out_rem_d;
    end
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.picked_x  = out_x_q;
  assign rsp_o.picked_y  = out_y_q;
  assign rsp_o.remaining = out_rem_q;

endmodule

`default_nettype wire

[src/rcp_checker.sv]
// Port checker of the random cell pool and its bind to the top level.
// Depends on rcp_pkg and random_cell_pool_macros.svh.
`default_nettype none

`include "random_cell_pool_macros.svh"

module rcp_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic                        ready_i,
  input  wire logic [1:0]                  status_i,
  input  wire logic [rcp_pkg::COORD_W-1:0] picked_x_i,
  input  wire logic [rcp_pkg::COORD_W-1:0] picked_y_i,
  input  wire logic [rcp_pkg::CNT_W-1:0]   remaining_i
);

  // A result that has not been taken stays offered.
  `RCP_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, valid_i && !ready_i, valid_i, "result dropped")

  // An empty pool can only be reported with no cells left and no coordinates.
  `RCP_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, valid_i && (status_i == rcp_pkg::ST_EMPTY), (remaining_i == '0) && (picked_x_i == '0) && (picked_y_i == '0), "empty pick with data")

  // A failed remove hands out no coordinates.
  `RCP_ASSERT_NOW(a_notfound_zero, clk_i, rst_ni, valid_i && (status_i == rcp_pkg::ST_NOT_FOUND), (picked_x_i == '0) && (picked_y_i == '0), "failed remove with data")

  // The live count never exceeds the grid.
  `RCP_ASSERT_NOW(a_count_range, clk_i, rst_ni, valid_i, remaining_i <= rcp_pkg::CNT_W'(rcp_pkg::CELL_TOTAL), "count above cell total")

endmodule

bind random_cell_pool rcp_checker u_rcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (rsp_o.valid),
  .ready_i     (rsp_o.ready),
  .status_i    (rsp_o.status),
  .picked_x_i  (rsp_o.picked_x),
  .picked_y_i  (rsp_o.picked_y),
  .remaining_i (rsp_o.remaining)
);

`default_nettype wire

[sim/testbench.sv]
// Testbench of the random cell pool: directed and random actions are sent
// on the request channel, and each result item is checked against the pool
// model or a typed row. Depends on rcp_pkg, rcp_if and random_cell_pool.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Action code 3 is not an action; the pool must leave its state alone.
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int RANDOM_ITEMS = 1050;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    rcp_pkg::status_e              status;
    logic [rcp_pkg::COORD_W-1:0]   x;
    logic [rcp_pkg::COORD_W-1:0]   y;
    logic [rcp_pkg::CNT_W-1:0]     remaining;
  } pool_result_t;

  typedef struct packed {
    logic [1:0]                    action;
    logic [rcp_pkg::RND_W-1:0]     rnd;
    logic [rcp_pkg::COORD_W-1:0]   tx;
    logic [rcp_pkg::COORD_W-1:0]   ty;
    logic                          typed;
    pool_result_t                  want;
  } pool_vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int counted_items = 0;
  bit random_part = 1'b0;

  // Model of the pool: cell numbers and the live count.
  logic [rcp_pkg::CELL_W-1:0] pool_cells [rcp_pkg::CELL_TOTAL];
  logic [rcp_pkg::CNT_W-1:0]  pool_count;
  pool_result_t               pending_results [$];

  // Directed rows. Rows with typed set carry a hand-written result; the
  // others are worked out by the pool model.
  pool_vector_t directed_tbl [16] = '{
    '{rcp_pkg::ACT_PICK, 15'd0, 4'd0, 4'd0, 1'b1, '{rcp_pkg::ST_OK, 4'd0, 4'd0, 9'd255}},
    '{rcp_pkg::ACT_PICK, 15'h7FFF, 4'd0, 4'd0, 1'b0, '0},
    '{rcp_pkg::ACT_PICK, 15'd1, 4'd15, 4'd15, 1'b0, '0},
    '{rcp_pkg::ACT_REMOVE, 15'd0, 4'd15, 4'd15, 1'b0, '0},
    '{rcp_pkg::ACT_REMOVE, 15'h7FFF, 4'd0, 4'd0, 1'b1,
      '{rcp_pkg::ST_NOT_FOUND, 4'd0, 4'd0, 9'd252}},
    '{rcp_pkg::ACT_REMOVE, 15'd0, 4'd15, 4'd15, 1'b1,
      '{rcp_pkg::ST_NOT_FOUND, 4'd0, 4'd0, 9'd252}},
    '{ACT_IGNORED, 15'h7FFF, 4'd15, 4'd15, 1'b1, '{rcp_pkg::ST_OK, 4'd0, 4'd0, 9'd252}},
    '{rcp_pkg::ACT_REFILL, 15'h7FFF, 4'd15, 4'd15, 1'b1,
      '{rcp_pkg::ST_OK, 4'd0, 4'd0, 9'd256}},
    '{rcp_pkg::ACT_REMOVE, 15'd0, 4'd15, 4'd15, 1'b1,
      '{rcp_pkg::ST_OK, 4'd0, 4'd0, 9'd255}},
    '{rcp_pkg::ACT_REMOVE, 15'd0, 4'd0, 4'd0, 1'b1, '{rcp_pkg::ST_OK, 4'd0, 4'd0, 9'd254}},
    '{rcp_pkg::ACT_PICK, 15'h7FFF, 4'd10, 4'd5, 1'b0, '0},
    '{rcp_pkg::ACT_PICK, 15'h3FFF, 4'd5, 4'd10, 1'b0, '0},
    '{rcp_pkg::ACT_REMOVE, 15'h5555, 4'd7, 4'd8, 1'b0, '0},
    '{rcp_pkg::ACT_REFILL, 15'd0, 4'd0, 4'd0, 1'b1, '{rcp_pkg::ST_OK, 4'd0, 4'd0, 9'd256}},
    '{rcp_pkg::ACT_PICK, 15'd255, 4'd0, 4'd0, 1'b1,
      '{rcp_pkg::ST_OK, 4'd15, 4'd15, 9'd255}},
    '{rcp_pkg::ACT_PICK, 15'h7FFF, 4'd0, 4'd0, 1'b0, '0}
  };

  rcp_req_if req_bus ();
  rcp_rsp_if rsp_bus ();

  random_cell_pool uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #5 clk = ~clk;

  // Restore identity order with every cell free.
  function automatic void pool_refill();
    for (int i = 0; i < rcp_pkg::CELL_TOTAL; i++) begin
      pool_cells[i] = rcp_pkg::CELL_W'(i);
    end
    pool_count = rcp_pkg::CNT_W'(rcp_pkg::CELL_TOTAL);
  endfunction

  // Swap-remove: the last live entry fills the vacated slot.
  function automatic void pool_take(int slot);
    pool_count = pool_count - 1'b1;
    pool_cells[slot] = pool_cells[pool_count];
  endfunction

  // Apply one action to the model and return the result it gives.
  function automatic pool_result_t pool_apply(logic [1:0] action,
                                              logic [rcp_pkg::RND_W-1:0] rnd,
                                              logic [rcp_pkg::COORD_W-1:0] tx,
                                              logic [rcp_pkg::COORD_W-1:0] ty);
    pool_result_t res;
    int slot;
    int target;
    logic [rcp_pkg::CELL_W-1:0] cell_num;
    res = '0;
    res.status = rcp_pkg::ST_OK;
    target = int'(ty) * rcp_pkg::GRID_SIDE + int'(tx);
    case (action)
      rcp_pkg::ACT_REFILL: begin
        pool_refill();
      end
      rcp_pkg::ACT_PICK: begin
        if (pool_count == 0) begin
          res.status = rcp_pkg::ST_EMPTY;
        end else begin
          slot = int'(rnd) % int'(pool_count);
          cell_num = pool_cells[slot];
          pool_take(slot);
          res.x = rcp_pkg::COORD_W'(int'(cell_num) % rcp_pkg::GRID_SIDE);
          res.y = rcp_pkg::COORD_W'(int'(cell_num) / rcp_pkg::GRID_SIDE);
        end
      end
      rcp_pkg::ACT_REMOVE: begin
        res.status = rcp_pkg::ST_NOT_FOUND;
        for (slot = 0; slot < int'(pool_count); slot++) begin
          if (int'(pool_cells[slot]) == target) begin
            pool_take(slot);
            res.status = rcp_pkg::ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    res.remaining = pool_count;
    return res;
  endfunction

  function automatic logic [rcp_pkg::RND_W-1:0] random_draw();
    if ($urandom_range(0, 1) == 0) begin
      return rcp_pkg::RND_W'($urandom_range(0, 511));
    end
    return rcp_pkg::RND_W'($urandom_range(0, 32767));
  endfunction

  // Send one item, idling first if the phase asks for it, and record the
  // expected result once the item has been accepted.
  task automatic send_item(logic [1:0] action, logic [rcp_pkg::RND_W-1:0] rnd,
                           logic [rcp_pkg::COORD_W-1:0] tx,
                           logic [rcp_pkg::COORD_W-1:0] ty,
                           logic typed, pool_result_t want);
    pool_result_t got;
    if (random_part) begin
      case (counted_items * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
    end
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_bus.valid        <= 1'b1;
    req_bus.action       <= action;
    req_bus.random_value <= rnd;
    req_bus.target_x     <= tx;
    req_bus.target_y     <= ty;
    do @(posedge clk); while (!req_bus.ready);
    got = pool_apply(action, rnd, tx, ty);
    pending_results.push_back(typed ? want : got);
    if (action != ACT_IGNORED) begin
      counted_items++;
    end
  endtask

  // Hold the request channel idle until every result has come back.
  task automatic wait_results_done();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string field, logic [rcp_pkg::CNT_W-1:0] want,
                                      logic [rcp_pkg::CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Result side: check each accepted item and stall at random.
  always @(posedge clk) begin
    pool_result_t want;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          $error("result item with none expected: status %0d remaining %0d",
                 rsp_bus.status, rsp_bus.remaining);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", rcp_pkg::CNT_W'(want.status),
                      rcp_pkg::CNT_W'(rsp_bus.status));
          check_field("picked_x", rcp_pkg::CNT_W'(want.x),
                      rcp_pkg::CNT_W'(rsp_bus.picked_x));
          check_field("picked_y", rcp_pkg::CNT_W'(want.y),
                      rcp_pkg::CNT_W'(rsp_bus.picked_y));
          check_field("remaining", want.remaining, rsp_bus.remaining);
        end
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Stimulus: reset, the directed table, then episodes of random items.
  initial begin
    int episode;
    logic [3:0] kind;
    logic [1:0] act;
    req_bus.valid        = 1'b0;
    req_bus.action       = rcp_pkg::ACT_REFILL;
    req_bus.random_value = '0;
    req_bus.target_x     = '0;
    req_bus.target_y     = '0;
    rsp_bus.ready        = 1'b0;
    pool_refill();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_tbl[i]) begin
      send_item(directed_tbl[i].action, directed_tbl[i].rnd, directed_tbl[i].tx,
                directed_tbl[i].ty, directed_tbl[i].typed, directed_tbl[i].want);
    end
    wait_results_done();

    counted_items = 0;
    random_part = 1'b1;
    episode = 0;
    while (counted_items < RANDOM_ITEMS) begin
      if (episode % 2 == 0) begin
        // Refill, then picks and removes until the pool runs dry or the
        // item budget is spent, then actions that fail if the pool is empty.
        send_item(rcp_pkg::ACT_REFILL, random_draw(), 4'($urandom), 4'($urandom),
                  1'b0, '0);
        while ((pool_count != 0) && (counted_items < RANDOM_ITEMS)) begin
          if ($urandom_range(0, 9) < 7) begin
            send_item(rcp_pkg::ACT_PICK, random_draw(), 4'($urandom), 4'($urandom),
                      1'b0, '0);
          end else begin
            send_item(rcp_pkg::ACT_REMOVE, random_draw(), 4'($urandom), 4'($urandom),
                      1'b0, '0);
          end
        end
        repeat (3) send_item(rcp_pkg::ACT_PICK, random_draw(), 4'($urandom),
                             4'($urandom), 1'b0, '0);
        repeat (2) send_item(rcp_pkg::ACT_REMOVE, random_draw(), 4'($urandom),
                             4'($urandom), 1'b0, '0);
        send_item(ACT_IGNORED, random_draw(), 4'($urandom), 4'($urandom), 1'b0, '0);
      end else begin
        // Noise: any action, refills and ignored codes now and then.
        repeat (40) begin
          kind = 4'($urandom);
          if (kind == 4'd0) begin
            act = rcp_pkg::ACT_REFILL;
          end else if (kind == 4'd1) begin
            act = ACT_IGNORED;
          end else if (kind[0]) begin
            act = rcp_pkg::ACT_PICK;
          end else begin
            act = rcp_pkg::ACT_REMOVE;
          end
          send_item(act, random_draw(), 4'($urandom), 4'($urandom), 1'b0, '0);
        end
      end
      episode++;
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung channel.
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

[random_cell_pool.f]
+incdir+src
src/rcp_pkg.sv
src/rcp_if.sv
src/rcp_mem.sv
src/rcp_mod.sv
src/random_cell_pool.sv
src/rcp_checker.sv
sim/testbench.sv
